// ===== rtl/apeq_pkg.sv =====
// Package for the aging priority event queue: command codes, config indices,
// state encoding and the input and output beat records. No dependencies.
package apeq_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CHOOSE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] CFG_FILTER_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_FILTER_PRIORITY = 2'd1;
    localparam logic [1:0] CFG_PRELOAD_TICKS   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_A,
        ST_SCAN_B,
        ST_CLEAN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_tick;
        logic [15:0] event_handle;
        logic [15:0] max_age;
        logic [15:0] priority_req;
        logic        filter_flag;
        logic        keep_flag;
        logic        d_tag;
        logic [7:0]  accept_prob;
        logic [6:0]  rand_draw;
    } in_beat_t;

    typedef struct packed {
        logic        added;
        logic [3:0]  slot_index;
        logic        evicted;
        logic        winner_found;
        logic [15:0] winner_handle;
        logic        kept_d_flag;
        logic [4:0]  live_count;
    } out_beat_t;

endpackage

// ===== rtl/apeq_if.sv =====
// Valid/ready channel interfaces for the event queue.
// Depends on apeq_pkg.
interface apeq_in_if;
    apeq_pkg::in_beat_t data;
    logic valid;
    logic ready;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface apeq_out_if;
    apeq_pkg::out_beat_t data;
    logic valid;
    logic ready;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/aging_priority_event_queue.sv =====
// Aging priority event queue: slot records held in one synchronous memory.
// Depends on apeq_pkg and apeq_if.
// An add scans all slots before its result beat; a choose on a non-empty queue
// scans, then clears if it found a winner; clear, no-op and empty choose do not scan.
// One item at a time, set by the memory walk; input waits for the result beat.
// Reset clears control state and valid bits; memory contents need no reset.
module aging_priority_event_queue #(
    parameter int SLOTS       = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    apeq_in_if.sink     in_ch,
    apeq_out_if.source  out_ch
);
    import apeq_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef struct packed {
        logic [31:0]            tick;
        logic [15:0]            sub;
        logic [15:0]            max_age;
        logic [15:0]            pri;
        logic                   filt;
        logic                   keep;
        logic                   dtag;
        logic [HANDLE_BITS-1:0] handle;
    } rec_t;

    rec_t mem [SLOTS];
    rec_t rd_reg;
    logic [IW-1:0] raddr;
    logic          we;
    logic [IW-1:0] waddr;
    rec_t          wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    logic                 filt_en_reg;
    logic [15:0]          filt_pri_reg;
    logic [15:0]          preload_reg;
    logic [SLOTS-1:0]     en_reg, en_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [31:0]          last_tick_reg, last_tick_next;
    logic [15:0]          last_sub_reg, last_sub_next;
    logic                 kd_reg, kd_next;
    state_t               st_reg, st_next;
    in_beat_t             in_reg, in_next;
    out_beat_t            out_reg, out_next;
    logic                 ov_reg, ov_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic                 rv_reg, rv_next;
    logic [IW-1:0]        ri_reg, ri_next;
    logic                 exp_found_reg, exp_found_next;
    logic [IW-1:0]        exp_idx_reg, exp_idx_next;
    logic                 pri_found_reg, pri_found_next;
    logic [IW-1:0]        pri_idx_reg, pri_idx_next;
    logic                 win_reg, win_next;
    logic [IW-1:0]        wi_reg, wi_next;
    logic [15:0]          bpri_reg, bpri_next;
    logic [31:0]          bage_reg, bage_next;
    logic [15:0]          bsub_reg, bsub_next;
    logic [31:0]          wt_reg, wt_next;
    logic [HANDLE_BITS-1:0] wh_reg, wh_next;
    logic                 kdacc_reg, kdacc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_en_reg  <= 1'b0;
            filt_pri_reg <= '0;
            preload_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILTER_ENABLE:   filt_en_reg  <= cfg_data[0];
                CFG_FILTER_PRIORITY: filt_pri_reg <= cfg_data;
                CFG_PRELOAD_TICKS:   preload_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            en_reg        <= '0;
            cnt_reg       <= '0;
            last_tick_reg <= '0;
            last_sub_reg  <= '0;
            kd_reg        <= 1'b0;
            ov_reg        <= 1'b0;
            rv_reg        <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            en_reg        <= en_next;
            cnt_reg       <= cnt_next;
            last_tick_reg <= last_tick_next;
            last_sub_reg  <= last_sub_next;
            kd_reg        <= kd_next;
            ov_reg        <= ov_next;
            rv_reg        <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg        <= in_next;
        out_reg       <= out_next;
        ptr_reg       <= ptr_next;
        ri_reg        <= ri_next;
        exp_found_reg <= exp_found_next;
        exp_idx_reg   <= exp_idx_next;
        pri_found_reg <= pri_found_next;
        pri_idx_reg   <= pri_idx_next;
        win_reg       <= win_next;
        wi_reg        <= wi_next;
        bpri_reg      <= bpri_next;
        bage_reg      <= bage_next;
        bsub_reg      <= bsub_next;
        wt_reg        <= wt_next;
        wh_reg        <= wh_next;
        kdacc_reg     <= kdacc_next;
    end

    assign in_ch.ready  = (st_reg == ST_IDLE) && !ov_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = out_reg;

    logic [31:0] ref_tick;
    logic [31:0] age_add, age_ch;
    logic        exp_add, exp_ch, filtered, rec_en;
    logic        accept;
    logic        first_free_found;
    logic [IW-1:0] first_free;
    logic        better, older;

    assign ref_tick = in_reg.now_tick + {16'd0, preload_reg};
    assign age_add  = in_reg.now_tick - rd_reg.tick;
    assign age_ch   = ref_tick - rd_reg.tick;
    assign rec_en   = en_reg[ri_reg];
    assign exp_add  = (rd_reg.max_age != 16'd0) && (age_add > {16'd0, rd_reg.max_age});
    assign exp_ch   = (rd_reg.max_age != 16'd0)
                   && ($signed(age_ch) > $signed({16'd0, rd_reg.max_age}));
    assign filtered = filt_en_reg && rd_reg.filt && (rd_reg.pri < filt_pri_reg);
    assign accept   = $signed({1'b0, in_reg.rand_draw}) <= $signed(in_reg.accept_prob);
    assign better   = (rd_reg.pri > bpri_reg)
                   || (win_reg && rd_reg.pri == bpri_reg
                       && ($signed(age_ch) < $signed(bage_reg)
                           || (age_ch == bage_reg && bsub_reg < rd_reg.sub)));
    assign older    = (rd_reg.tick < wt_reg)
                   || (rd_reg.tick == wt_reg && rd_reg.sub < bsub_reg);

    always_comb
    begin
        first_free_found = 1'b0;
        first_free       = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!en_reg[i])
            begin
                first_free_found = 1'b1;
                first_free       = IW'(i);
            end
        end
    end

    logic          sel_ok;
    logic [IW-1:0] sel_idx;
    logic          sel_ev;
    logic [15:0]   new_sub;

    always_comb
    begin
        st_next        = st_reg;
        en_next        = en_reg;
        cnt_next       = cnt_reg;
        last_tick_next = last_tick_reg;
        last_sub_next  = last_sub_reg;
        kd_next        = kd_reg;
        in_next        = in_reg;
        out_next       = out_reg;
        ov_next        = ov_reg;
        ptr_next       = ptr_reg;
        rv_next        = 1'b0;
        ri_next        = ri_reg;
        exp_found_next = exp_found_reg;
        exp_idx_next   = exp_idx_reg;
        pri_found_next = pri_found_reg;
        pri_idx_next   = pri_idx_reg;
        win_next       = win_reg;
        wi_next        = wi_reg;
        bpri_next      = bpri_reg;
        bage_next      = bage_reg;
        bsub_next      = bsub_reg;
        wt_next        = wt_reg;
        wh_next        = wh_reg;
        kdacc_next     = kdacc_reg;
        raddr          = ptr_reg[IW-1:0];
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        sel_ok         = 1'b0;
        sel_idx        = '0;
        sel_ev         = 1'b0;
        new_sub        = '0;

        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        case (st_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    in_next        = in_ch.data;
                    ptr_next       = '0;
                    exp_found_next = 1'b0;
                    pri_found_next = 1'b0;
                    win_next       = 1'b0;
                    bpri_next      = '0;
                    bage_next      = '0;
                    bsub_next      = '0;
                    kdacc_next     = 1'b0;
                    case (in_ch.data.cmd)
                        CMD_ADD:    st_next = ST_SCAN_A;
                        CMD_CHOOSE: st_next = (cnt_reg != '0) ? ST_SCAN_B : ST_OUT;
                        CMD_CLEAR:
                        begin
                            en_next  = '0;
                            cnt_next = '0;
                            st_next  = ST_OUT;
                        end
                        default:    st_next = ST_OUT;
                    endcase
                end
            end
            ST_SCAN_A:
            begin
                if (ptr_reg < CW'(SLOTS))
                begin
                    raddr    = ptr_reg[IW-1:0];
                    rv_next  = 1'b1;
                    ri_next  = ptr_reg[IW-1:0];
                    ptr_next = ptr_reg + 1'b1;
                end
                if (rv_reg)
                begin
                    if (!exp_found_reg && exp_add)
                    begin
                        exp_found_next = 1'b1;
                        exp_idx_next   = ri_reg;
                    end
                    if (!pri_found_reg && rd_reg.pri <= in_reg.priority_req)
                    begin
                        pri_found_next = 1'b1;
                        pri_idx_next   = ri_reg;
                    end
                end
                else if (ptr_reg == CW'(SLOTS))
                begin
                    if (first_free_found)
                    begin
                        sel_ok  = 1'b1;
                        sel_idx = first_free;
                    end
                    else if (exp_found_reg)
                    begin
                        sel_ok  = 1'b1;
                        sel_idx = exp_idx_reg;
                        sel_ev  = 1'b1;
                    end
                    else if (pri_found_reg)
                    begin
                        sel_ok  = 1'b1;
                        sel_idx = pri_idx_reg;
                        sel_ev  = 1'b1;
                    end
                    out_next = '0;
                    if (accept && sel_ok)
                    begin
                        new_sub = (in_reg.now_tick == last_tick_reg)
                                ? last_sub_reg + 16'd1 : 16'd0;
                        last_sub_next  = new_sub;
                        last_tick_next = in_reg.now_tick;
                        we             = 1'b1;
                        waddr          = sel_idx;
                        wdata.tick     = in_reg.now_tick;
                        wdata.sub      = new_sub;
                        wdata.max_age  = in_reg.max_age;
                        wdata.pri      = in_reg.priority_req;
                        wdata.filt     = in_reg.filter_flag;
                        wdata.keep     = in_reg.keep_flag;
                        wdata.dtag     = in_reg.d_tag;
                        wdata.handle   = HANDLE_BITS'(in_reg.event_handle);
                        en_next[sel_idx] = 1'b1;
                        if (!sel_ev)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        out_next.added      = 1'b1;
                        out_next.slot_index = 4'(sel_idx);
                        out_next.evicted    = sel_ev;
                    end
                    out_next.kept_d_flag = kd_reg;
                    out_next.live_count  = 5'(cnt_next);
                    ov_next = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            ST_SCAN_B:
            begin
                if (ptr_reg < CW'(SLOTS))
                begin
                    raddr    = ptr_reg[IW-1:0];
                    rv_next  = 1'b1;
                    ri_next  = ptr_reg[IW-1:0];
                    ptr_next = ptr_reg + 1'b1;
                end
                if (rv_reg && rec_en)
                begin
                    if (exp_ch || filtered)
                    begin
                        en_next[ri_reg] = 1'b0;
                        cnt_next        = cnt_reg - 1'b1;
                    end
                    else if (better)
                    begin
                        win_next  = 1'b1;
                        wi_next   = ri_reg;
                        bpri_next = rd_reg.pri;
                        bage_next = age_ch;
                        bsub_next = rd_reg.sub;
                        wt_next   = rd_reg.tick;
                        wh_next   = rd_reg.handle;
                    end
                end
                else if (!rv_reg && ptr_reg == CW'(SLOTS))
                begin
                    ptr_next = '0;
                    st_next  = win_reg ? ST_CLEAN : ST_OUT;
                end
            end
            ST_CLEAN:
            begin
                if (ptr_reg < CW'(SLOTS))
                begin
                    raddr    = ptr_reg[IW-1:0];
                    rv_next  = 1'b1;
                    ri_next  = ptr_reg[IW-1:0];
                    ptr_next = ptr_reg + 1'b1;
                end
                if (rv_reg && rec_en && ri_reg != wi_reg)
                begin
                    if (older)
                    begin
                        if (!rd_reg.keep)
                        begin
                            en_next[ri_reg] = 1'b0;
                            cnt_next        = cnt_reg - 1'b1;
                        end
                    end
                    else if (rd_reg.dtag)
                    begin
                        kdacc_next = 1'b1;
                    end
                end
                else if (!rv_reg && ptr_reg == CW'(SLOTS))
                begin
                    en_next[wi_reg] = 1'b0;
                    cnt_next        = cnt_reg - 1'b1;
                    kd_next         = kdacc_reg;
                    st_next         = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_next = '0;
                if (in_reg.cmd == CMD_CHOOSE && win_reg)
                begin
                    out_next.winner_found  = 1'b1;
                    out_next.slot_index    = 4'(wi_reg);
                    out_next.winner_handle = 16'(wh_reg);
                end
                out_next.kept_d_flag = kd_reg;
                out_next.live_count  = 5'(cnt_reg);
                ov_next = 1'b1;
                st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for aging_priority_event_queue: drives add, choose,
// clear and idle commands and checks each result beat against a local model.
// Depends on apeq_pkg, apeq_if and the RTL top level.
`timescale 1ns / 100ps

module tb_top;
    import apeq_pkg::*;

    localparam int NSLOT = 16;
    localparam logic [1:0] CMD_NOP = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    apeq_in_if in_ch ();
    apeq_out_if out_ch ();

    aging_priority_event_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // queue model state
    logic        cfg_filter_on;
    logic [15:0] cfg_filter_pri;
    logic [15:0] cfg_preload;
    logic        slot_on [NSLOT];
    logic [31:0] slot_tick [NSLOT];
    logic [15:0] slot_sub [NSLOT];
    logic [15:0] slot_age_lim [NSLOT];
    logic [15:0] slot_pri [NSLOT];
    logic        slot_filt [NSLOT];
    logic        slot_keep [NSLOT];
    logic        slot_dtag [NSLOT];
    logic [15:0] slot_handle [NSLOT];
    int          live_slots;
    logic [31:0] prev_add_tick;
    logic [15:0] prev_sub;
    logic        d_survived;

    in_beat_t  pending_beats[$];
    out_beat_t expected_results[$];
    logic      in_fire;
    logic      no_idle;
    logic      long_hold;
    int        send_gap;
    int        hold_cnt;
    int        errors;
    int        n_stored;
    int        n_evicted;
    int        n_winners;
    logic [31:0] cur_tick;

    function automatic out_beat_t queue_step(in_beat_t b);
        out_beat_t r;
        int s;
        int win;
        int best_pri;
        int best_age;
        int age;
        logic [15:0] best_sub;
        logic [31:0] ref_tick;
        logic ev;
        logic expired;
        logic filtered;
        r = '0;
        if (b.cmd == CMD_ADD) begin
            if (int'(b.rand_draw) <= int'($signed(b.accept_prob))) begin
                s = -1;
                ev = 1'b0;
                if (live_slots < NSLOT)
                    for (int i = 0; i < NSLOT; i++)
                        if (s < 0 && !slot_on[i]) s = i;
                if (s < 0)
                    for (int i = 0; i < NSLOT; i++)
                        if (s < 0 && slot_age_lim[i] != 0 &&
                            (b.now_tick - slot_tick[i]) > {16'd0, slot_age_lim[i]})
                        begin
                            s = i;
                            ev = 1'b1;
                        end
                if (s < 0)
                    for (int i = 0; i < NSLOT; i++)
                        if (s < 0 && slot_pri[i] <= b.priority_req) begin
                            s = i;
                            ev = 1'b1;
                        end
                if (s >= 0) begin
                    if (slot_on[s]) live_slots--;
                    prev_sub = (b.now_tick == prev_add_tick) ? prev_sub + 16'd1 : 16'd0;
                    prev_add_tick = b.now_tick;
                    slot_age_lim[s] = b.max_age;
                    slot_pri[s] = b.priority_req;
                    slot_filt[s] = b.filter_flag;
                    slot_keep[s] = b.keep_flag;
                    slot_dtag[s] = b.d_tag;
                    slot_handle[s] = b.event_handle;
                    slot_tick[s] = b.now_tick;
                    slot_sub[s] = prev_sub;
                    slot_on[s] = 1'b1;
                    live_slots++;
                    r.added = 1'b1;
                    r.slot_index = s[3:0];
                    r.evicted = ev;
                    n_stored++;
                    if (ev) n_evicted++;
                end
            end
        end else if (b.cmd == CMD_CHOOSE && live_slots != 0) begin
            ref_tick = b.now_tick + {16'd0, cfg_preload};
            win = -1;
            best_pri = 0;
            best_age = 0;
            best_sub = '0;
            for (int i = 0; i < NSLOT; i++) begin
                if (slot_on[i]) begin
                    age = $signed(ref_tick - slot_tick[i]);
                    expired = slot_age_lim[i] != 0 && age > int'(slot_age_lim[i]);
                    filtered = cfg_filter_on && slot_filt[i] && slot_pri[i] < cfg_filter_pri;
                    if (expired || filtered) begin
                        slot_on[i] = 1'b0;
                        live_slots--;
                    end else if (int'(slot_pri[i]) > best_pri) begin
                        win = i;
                        best_pri = int'(slot_pri[i]);
                        best_age = age;
                        best_sub = slot_sub[i];
                    end else if (win >= 0 && int'(slot_pri[i]) == best_pri) begin
                        if (age < best_age || (age == best_age && best_sub < slot_sub[i])) begin
                            win = i;
                            best_age = age;
                            best_sub = slot_sub[i];
                        end
                    end
                end
            end
            if (win >= 0) begin
                d_survived = 1'b0;
                for (int i = 0; i < NSLOT; i++) begin
                    if (i != win && slot_on[i]) begin
                        if (slot_tick[i] < slot_tick[win] ||
                            (slot_tick[i] == slot_tick[win] && slot_sub[i] < slot_sub[win]))
                        begin
                            if (!slot_keep[i]) begin
                                slot_on[i] = 1'b0;
                                live_slots--;
                            end
                        end else if (slot_dtag[i]) begin
                            d_survived = 1'b1;
                        end
                    end
                end
                slot_on[win] = 1'b0;
                live_slots--;
                r.winner_found = 1'b1;
                r.slot_index = win[3:0];
                r.winner_handle = slot_handle[win];
                n_winners++;
            end
        end else if (b.cmd == CMD_CLEAR) begin
            for (int i = 0; i < NSLOT; i++) slot_on[i] = 1'b0;
            live_slots = 0;
        end
        r.kept_d_flag = d_survived;
        r.live_count = live_slots[4:0];
        return r;
    endfunction

    function automatic logic [31:0] advance_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) ;
        else if (r < 85) cur_tick = cur_tick + $urandom_range(1, 4);
        else if (r < 92) cur_tick = cur_tick + $urandom_range(5, 40);
        else if (r < 96) cur_tick = cur_tick - $urandom_range(1, 3);
        else cur_tick = $urandom;
        return cur_tick;
    endfunction

    function automatic in_beat_t make_beat(logic [1:0] cmd);
        in_beat_t b;
        int r;
        b.cmd = cmd;
        b.now_tick = advance_tick();
        b.event_handle = 16'($urandom);
        r = $urandom_range(0, 9);
        b.max_age = (r < 3) ? 16'd0 : (r < 9) ? 16'($urandom_range(1, 12)) : 16'($urandom);
        r = $urandom_range(0, 19);
        b.priority_req = (r < 16) ? 16'($urandom_range(0, 8)) :
                         (r < 18) ? 16'($urandom) : 16'hFFFF;
        b.filter_flag = 1'($urandom_range(0, 1));
        b.keep_flag = ($urandom_range(0, 3) == 0);
        b.d_tag = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 9);
        b.accept_prob = (r < 7) ? 8'sd127 : (r < 8) ? 8'sd100 : 8'($urandom);
        b.rand_draw = 7'($urandom_range(0, 99));
        return b;
    endfunction

    function automatic logic [1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 62) return CMD_ADD;
        if (r < 92) return CMD_CHOOSE;
        if (r < 96) return CMD_CLEAR;
        return CMD_NOP;
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_FILTER_ENABLE:   cfg_filter_on = val[0];
            CFG_FILTER_PRIORITY: cfg_filter_pri = val;
            CFG_PRELOAD_TICKS:   cfg_preload = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_beats.size() != 0 || in_ch.valid || expected_results.size() != 0);
        repeat (50) @(negedge clk);
    endtask

    task automatic queue_random(int n);
        for (int k = 0; k < n; k++) pending_beats.push_back(make_beat(pick_cmd()));
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always #5 clk = ~clk;

    always @(posedge clk) begin
        in_fire <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
            expected_results.push_back(queue_step(in_ch.data));
    end

    always @(posedge clk) begin
        out_beat_t e;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
            end else begin
                e = expected_results.pop_front();
                check_field("added", e.added, out_ch.data.added);
                check_field("slot_index", e.slot_index, out_ch.data.slot_index);
                check_field("evicted", e.evicted, out_ch.data.evicted);
                check_field("winner_found", e.winner_found, out_ch.data.winner_found);
                check_field("winner_handle", e.winner_handle, out_ch.data.winner_handle);
                check_field("kept_d_flag", e.kept_d_flag, out_ch.data.kept_d_flag);
                check_field("live_count", e.live_count, out_ch.data.live_count);
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n && (!in_ch.valid || in_fire)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                in_ch.data <= pending_beats.pop_front();
                in_ch.valid <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 8);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (long_hold) begin
                out_ch.ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0) hold_cnt = $urandom_range(1, 8);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        in_beat_t b;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        in_fire = 1'b0;
        no_idle = 1'b0;
        long_hold = 1'b0;
        send_gap = 0;
        hold_cnt = 0;
        errors = 0;
        n_stored = 0;
        n_evicted = 0;
        n_winners = 0;
        cfg_filter_on = 1'b0;
        cfg_filter_pri = '0;
        cfg_preload = '0;
        for (int i = 0; i < NSLOT; i++) begin
            slot_on[i] = 1'b0;
            slot_tick[i] = '0;
            slot_sub[i] = '0;
            slot_age_lim[i] = '0;
            slot_pri[i] = '0;
            slot_filt[i] = 1'b0;
            slot_keep[i] = 1'b0;
            slot_dtag[i] = 1'b0;
            slot_handle[i] = '0;
        end
        live_slots = 0;
        prev_add_tick = '0;
        prev_sub = '0;
        d_survived = 1'b0;
        cur_tick = 32'hFFFF_FFF0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reject at lowest threshold, accept at zero threshold
        b = make_beat(CMD_ADD);
        b.accept_prob = 8'h80;
        b.rand_draw = 7'd0;
        pending_beats.push_back(b);
        // fill every slot at one tick
        for (int i = 0; i < NSLOT; i++) begin
            b = make_beat(CMD_ADD);
            b.now_tick = 32'hFFFF_FFFE;
            b.accept_prob = (i == 0) ? 8'sd0 : 8'sd127;
            b.rand_draw = (i == 0) ? 7'd0 : 7'd99;
            b.priority_req = (i == 1) ? 16'hFFFF : 16'(i % 4 + 1);
            b.max_age = (i < 4) ? 16'd2 : 16'd0;
            b.event_handle = (i == 2) ? 16'hFFFF : (i == 3) ? 16'h0000 : 16'($urandom);
            b.keep_flag = i[0];
            b.d_tag = i[1];
            b.filter_flag = i[2];
            pending_beats.push_back(b);
        end
        // full: zero priority is dropped, then eviction by priority, then by expiry
        b = make_beat(CMD_ADD);
        b.now_tick = 32'hFFFF_FFFE;
        b.priority_req = 16'd0;
        b.accept_prob = 8'sd127;
        pending_beats.push_back(b);
        b.priority_req = 16'd9;
        pending_beats.push_back(b);
        b.now_tick = 32'h0000_0003;
        b.priority_req = 16'd0;
        b.max_age = 16'hFFFF;
        pending_beats.push_back(b);
        b = make_beat(CMD_CHOOSE);
        b.now_tick = 32'h0000_0003;
        pending_beats.push_back(b);
        pending_beats.push_back(b);
        b.cmd = CMD_NOP;
        pending_beats.push_back(b);
        b.cmd = CMD_CLEAR;
        pending_beats.push_back(b);
        b.cmd = CMD_CHOOSE;
        pending_beats.push_back(b);
        cur_tick = 32'h0000_0003;
        queue_random(300);
        wait_drained();

        cfg_write(CFG_FILTER_ENABLE, 16'd1);
        cfg_write(CFG_FILTER_PRIORITY, 16'd4);
        cfg_write(CFG_PRELOAD_TICKS, 16'd0);
        queue_random(300);
        repeat (20) @(posedge clk);
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
        wait_drained();

        cfg_write(CFG_FILTER_PRIORITY, 16'hFFFF);
        cfg_write(CFG_PRELOAD_TICKS, 16'hFFFF);
        queue_random(250);
        wait_drained();

        cfg_write(CFG_FILTER_ENABLE, 16'd0);
        cfg_write(CFG_PRELOAD_TICKS, 16'd7);
        queue_random(250);
        wait_drained();

        cfg_write(CFG_FILTER_ENABLE, 16'd1);
        cfg_write(CFG_FILTER_PRIORITY, 16'd0);
        cfg_write(CFG_PRELOAD_TICKS, 16'd0);
        no_idle = 1'b1;
        queue_random(250);
        wait_drained();

        $display("Run covered %0d stored events (%0d evictions) and %0d winners",
                 n_stored, n_evicted, n_winners);
        $display("over five filter and preload settings, with a long output stall.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
